/* hdl/rc4_candidate_key_check_assert.svh */
// ----------------------------------------------------------------------------
// RC4 candidate key check: assertion macros
// Shared concurrent assertion forms; clock is clk, reset is rst_n.
// ----------------------------------------------------------------------------
`ifndef RC4_CANDIDATE_KEY_CHECK_ASSERT_SVH
`define RC4_CANDIDATE_KEY_CHECK_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define RC4CKC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define RC4CKC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rc4ckc_pkg.sv */
// ----------------------------------------------------------------------------
// rc4ckc_pkg
// Constants, command and status types shared by the RC4 key check block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rc4ckc_pkg;

    // Sizing
    localparam int CHECK_BYTES      = 6;
    localparam int KEY_BUFFER_BYTES = 32;
    localparam int IV_BYTES         = 3;
    localparam int SECRET_MAX       = KEY_BUFFER_BYTES - IV_BYTES;
    localparam int CARRIED_EXPECT   = 6;

    localparam int LEN_W     = 5;
    localparam int KEY_IDX_W = $clog2(KEY_BUFFER_BYTES);
    localparam int CHK_W     = (CHECK_BYTES > 1) ? $clog2(CHECK_BYTES) : 1;

    // Field widths
    localparam int IV_W     = 24;
    localparam int PART_W   = 64;
    localparam int PART3_W  = 40;
    localparam int EXPECT_W = 48;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_SECRET_KEY_LENGTH = '0;
    localparam logic [LEN_W-1:0]   LEN_RESET             = LEN_W'(5);

    // Datapath operations, one per controller step
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_INIT,
        OP_KRI,
        OP_KRJ,
        OP_KWI,
        OP_KFLUSH,
        OP_PRA,
        OP_PRB,
        OP_PWA,
        OP_PRK,
        OP_PCMP
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic idx_last;    // table index at 255
        logic check_last;  // last keystream byte under compare
    } dp_status_t;

endpackage

`default_nettype wire

/* hdl/rc4ckc_ctrl.sv */
// ----------------------------------------------------------------------------
// rc4ckc_ctrl
// Sequencer: table fill, key schedule, keystream compare, result strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rc4_candidate_key_check_assert.svh"

module rc4ckc_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire rc4ckc_pkg::dp_status_t status,
    output rc4ckc_pkg::dp_cmd_t         cmd,
    output logic                        busy,
    output logic                        done
);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_INIT   = 12'b0000_0000_0010,
        ST_KRI    = 12'b0000_0000_0100,
        ST_KRJ    = 12'b0000_0000_1000,
        ST_KWI    = 12'b0000_0001_0000,
        ST_KFLUSH = 12'b0000_0010_0000,
        ST_PRA    = 12'b0000_0100_0000,
        ST_PRB    = 12'b0000_1000_0000,
        ST_PWA    = 12'b0001_0000_0000,
        ST_PRK    = 12'b0010_0000_0000,
        ST_PCMP   = 12'b0100_0000_0000,
        ST_DONE   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = rc4ckc_pkg::OP_IDLE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = rc4ckc_pkg::OP_LOAD;
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.op = rc4ckc_pkg::OP_INIT;
                if (status.idx_last)
                begin
                    state_next = ST_KRI;
                end
            end
            ST_KRI:
            begin
                cmd.op     = rc4ckc_pkg::OP_KRI;
                state_next = ST_KRJ;
            end
            ST_KRJ:
            begin
                cmd.op     = rc4ckc_pkg::OP_KRJ;
                state_next = ST_KWI;
            end
            ST_KWI:
            begin
                cmd.op     = rc4ckc_pkg::OP_KWI;
                state_next = status.idx_last ? ST_KFLUSH : ST_KRI;
            end
            ST_KFLUSH:
            begin
                cmd.op     = rc4ckc_pkg::OP_KFLUSH;
                state_next = ST_PRA;
            end
            ST_PRA:
            begin
                cmd.op     = rc4ckc_pkg::OP_PRA;
                state_next = ST_PRB;
            end
            ST_PRB:
            begin
                cmd.op     = rc4ckc_pkg::OP_PRB;
                state_next = ST_PWA;
            end
            ST_PWA:
            begin
                cmd.op     = rc4ckc_pkg::OP_PWA;
                state_next = ST_PRK;
            end
            ST_PRK:
            begin
                cmd.op     = rc4ckc_pkg::OP_PRK;
                state_next = ST_PCMP;
            end
            ST_PCMP:
            begin
                cmd.op     = rc4ckc_pkg::OP_PCMP;
                state_next = status.check_last ? ST_DONE : ST_PRA;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

    // Checks
    `RC4CKC_ASSERT_NEXT(a_accept_busy, start && !busy, busy,
        "accepted item did not raise busy")
    `RC4CKC_ASSERT_NEXT(a_done_single, done, !done && !busy,
        "result strobe longer than one cycle")
    `RC4CKC_ASSERT_IMPL(a_done_after_cmp, $rose(done), $past(state_reg == ST_PCMP),
        "result strobe without a finished compare")

endmodule

`default_nettype wire

/* hdl/rc4ckc_datapath.sv */
// ----------------------------------------------------------------------------
// rc4ckc_datapath
// Permutation RAM, key and expected-byte buffers, index registers, compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rc4_candidate_key_check_assert.svh"

module rc4ckc_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire rc4ckc_pkg::dp_cmd_t                  cmd,
    output rc4ckc_pkg::dp_status_t                    status,
    input  wire logic [rc4ckc_pkg::LEN_W-1:0]         secret_key_length,
    input  wire logic [rc4ckc_pkg::IV_W-1:0]          iv_bytes,
    input  wire logic [rc4ckc_pkg::PART_W-1:0]        key_part0,
    input  wire logic [rc4ckc_pkg::PART_W-1:0]        key_part1,
    input  wire logic [rc4ckc_pkg::PART_W-1:0]        key_part2,
    input  wire logic [rc4ckc_pkg::PART3_W-1:0]       key_part3,
    input  wire logic [rc4ckc_pkg::EXPECT_W-1:0]      expected_stream,
    output logic                                      key_matches
);

    // Permutation RAM, registered read with write bypass
    logic [7:0] perm_mem [256];
    logic       mem_we;
    logic [7:0] mem_waddr;
    logic [7:0] mem_wdata;
    logic [7:0] mem_raddr;
    logic [7:0] rd_data_reg;

    // Buffers loaded at accept
    logic [7:0] key_reg [rc4ckc_pkg::KEY_BUFFER_BYTES];
    logic [7:0] key_next [rc4ckc_pkg::KEY_BUFFER_BYTES];
    logic [7:0] exp_reg [rc4ckc_pkg::CHECK_BYTES];
    logic [7:0] exp_next [rc4ckc_pkg::CHECK_BYTES];
    logic [rc4ckc_pkg::KEY_IDX_W-1:0] key_last_reg;
    logic [rc4ckc_pkg::KEY_IDX_W-1:0] key_last_next;
    logic [rc4ckc_pkg::LEN_W-1:0]     secret_len;

    // Index and swap registers
    logic [7:0]                       i_reg, i_next;
    logic [7:0]                       j_reg, j_next;
    logic [7:0]                       sa_reg, sa_next;
    logic [7:0]                       sb_reg, sb_next;
    logic [rc4ckc_pkg::KEY_IDX_W-1:0] kidx_reg, kidx_next;
    logic [rc4ckc_pkg::CHK_W-1:0]     chk_reg, chk_next;
    logic                             match_reg, match_next;

    logic [7:0] key_byte;
    logic [7:0] j_sum;
    logic [7:0] b_sum;
    logic [7:0] out_idx;

    // Key buffer: IV bytes then secret bytes
    always_comb
    begin
        for (int k = 0; k < rc4ckc_pkg::KEY_BUFFER_BYTES; k++)
        begin
            if (k < rc4ckc_pkg::IV_BYTES)
            begin
                key_next[k] = iv_bytes[8*k +: 8];
            end
            else if (k - rc4ckc_pkg::IV_BYTES < 8)
            begin
                key_next[k] = key_part0[8*((k - rc4ckc_pkg::IV_BYTES) % 8) +: 8];
            end
            else if (k - rc4ckc_pkg::IV_BYTES < 16)
            begin
                key_next[k] = key_part1[8*((k - rc4ckc_pkg::IV_BYTES) % 8) +: 8];
            end
            else if (k - rc4ckc_pkg::IV_BYTES < 24)
            begin
                key_next[k] = key_part2[8*((k - rc4ckc_pkg::IV_BYTES) % 8) +: 8];
            end
            else
            begin
                key_next[k] = key_part3[8*((k - rc4ckc_pkg::IV_BYTES) % 8) +: 8];
            end
        end
    end

    // Expected bytes, zero past the carried ones
    always_comb
    begin
        for (int k = 0; k < rc4ckc_pkg::CHECK_BYTES; k++)
        begin
            if (k < rc4ckc_pkg::CARRIED_EXPECT)
            begin
                exp_next[k] = expected_stream[8*k +: 8];
            end
            else
            begin
                exp_next[k] = 8'h00;
            end
        end
    end

    // Saturated key length, kept as index of the last key byte
    always_comb
    begin
        if (secret_key_length == '0)
        begin
            secret_len = rc4ckc_pkg::LEN_W'(1);
        end
        else if (secret_key_length > rc4ckc_pkg::LEN_W'(rc4ckc_pkg::SECRET_MAX))
        begin
            secret_len = rc4ckc_pkg::LEN_W'(rc4ckc_pkg::SECRET_MAX);
        end
        else
        begin
            secret_len = secret_key_length;
        end
        key_last_next = rc4ckc_pkg::KEY_IDX_W'(secret_len)
                      + rc4ckc_pkg::KEY_IDX_W'(rc4ckc_pkg::IV_BYTES - 1);
    end

    assign key_byte = key_reg[kidx_reg];
    assign j_sum    = j_reg + rd_data_reg + key_byte;
    assign b_sum    = j_reg + rd_data_reg;
    assign out_idx  = sa_reg + sb_reg;

    // Step decode
    always_comb
    begin
        i_next     = i_reg;
        j_next     = j_reg;
        sa_next    = sa_reg;
        sb_next    = sb_reg;
        kidx_next  = kidx_reg;
        chk_next   = chk_reg;
        match_next = match_reg;
        mem_we     = 1'b0;
        mem_waddr  = i_reg;
        mem_wdata  = i_reg;
        mem_raddr  = i_reg;
        unique case (cmd.op)
            rc4ckc_pkg::OP_IDLE:
            begin
            end
            rc4ckc_pkg::OP_LOAD:
            begin
                i_next     = 8'h00;
                j_next     = 8'h00;
                kidx_next  = '0;
                chk_next   = '0;
                match_next = 1'b1;
            end
            rc4ckc_pkg::OP_INIT:
            begin
                // identity fill
                mem_we = 1'b1;
                i_next = i_reg + 8'h01;
            end
            rc4ckc_pkg::OP_KRI:
            begin
                // read S[i]; finish previous swap with S[j] = old S[i]
                mem_we    = (i_reg != 8'h00);
                mem_waddr = j_reg;
                mem_wdata = sa_reg;
            end
            rc4ckc_pkg::OP_KRJ:
            begin
                sa_next   = rd_data_reg;
                j_next    = j_sum;
                mem_raddr = j_sum;
                kidx_next = (kidx_reg == key_last_reg) ? '0
                          : kidx_reg + rc4ckc_pkg::KEY_IDX_W'(1);
            end
            rc4ckc_pkg::OP_KWI:
            begin
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg;
                i_next    = i_reg + 8'h01;
            end
            rc4ckc_pkg::OP_KFLUSH:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = sa_reg;
                i_next    = 8'h00;
                j_next    = 8'h00;
            end
            rc4ckc_pkg::OP_PRA:
            begin
                i_next    = i_reg + 8'h01;
                mem_raddr = i_reg + 8'h01;
            end
            rc4ckc_pkg::OP_PRB:
            begin
                sa_next   = rd_data_reg;
                j_next    = b_sum;
                mem_raddr = b_sum;
            end
            rc4ckc_pkg::OP_PWA:
            begin
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg;
                sb_next   = rd_data_reg;
            end
            rc4ckc_pkg::OP_PRK:
            begin
                // S[b] = old S[a]; output index is the same sum after the swap
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = sa_reg;
                mem_raddr = out_idx;
            end
            rc4ckc_pkg::OP_PCMP:
            begin
                match_next = match_reg & (rd_data_reg == exp_reg[chk_reg]);
                chk_next   = chk_reg + rc4ckc_pkg::CHK_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // RAM write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            perm_mem[mem_waddr] <= mem_wdata;
        end
    end

    // RAM read port, same-cycle write forwarded
    always_ff @(posedge clk)
    begin
        if (mem_we && (mem_waddr == mem_raddr))
        begin
            rd_data_reg <= mem_wdata;
        end
        else
        begin
            rd_data_reg <= perm_mem[mem_raddr];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg     <= 8'h00;
            j_reg     <= 8'h00;
            kidx_reg  <= '0;
            chk_reg   <= '0;
            match_reg <= 1'b0;
        end
        else
        begin
            i_reg     <= i_next;
            j_reg     <= j_next;
            kidx_reg  <= kidx_next;
            chk_reg   <= chk_next;
            match_reg <= match_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sa_reg <= sa_next;
        sb_reg <= sb_next;
        if (cmd.op == rc4ckc_pkg::OP_LOAD)
        begin
            key_reg      <= key_next;
            exp_reg      <= exp_next;
            key_last_reg <= key_last_next;
        end
    end

    assign status.idx_last   = (i_reg == 8'hFF);
    assign status.check_last = (chk_reg == rc4ckc_pkg::CHK_W'(rc4ckc_pkg::CHECK_BYTES - 1));
    assign key_matches       = match_reg;

    // Checks
    `RC4CKC_ASSERT_NEXT(a_load_clears, cmd.op == rc4ckc_pkg::OP_LOAD,
        match_reg && (i_reg == 8'h00) && (kidx_reg == '0),
        "load did not clear the step state")
    `RC4CKC_ASSERT_NEXT(a_ksa_wrap, (cmd.op == rc4ckc_pkg::OP_KWI) && status.idx_last,
        (i_reg == 8'h00) && (cmd.op == rc4ckc_pkg::OP_KFLUSH),
        "key schedule did not end after the last index")
    `RC4CKC_ASSERT_IMPL(a_cmp_in_range, cmd.op == rc4ckc_pkg::OP_PCMP,
        !(chk_reg > rc4ckc_pkg::CHK_W'(rc4ckc_pkg::CHECK_BYTES - 1)),
        "compare past the last keystream byte")

endmodule

`default_nettype wire

/* hdl/rc4_candidate_key_check.sv */
// ----------------------------------------------------------------------------
// rc4_candidate_key_check
// Tests one RC4 candidate key (IV + secret bytes) against six keystream bytes.
// ----------------------------------------------------------------------------
//  Channel   Handshake                      Payload
//  input     start & !busy                  iv_bytes, key_part0..3, expected_stream
//  result    done (one-cycle strobe)        key_matches
//  config    psel & penable & pwrite        paddr, pwdata (secret_key_length @ 0)
//
//  An item keeps busy high through 256 identity writes, three RAM accesses
//  for each of the 256 schedule swaps, a flush step, five accesses per
//  keystream byte and a result step. The permutation RAM has one read and
//  one write port. A new item is taken the cycle after done.
//  No clearing pass after reset: the table is rebuilt for every item.
//  The result strobe cannot be stalled; key_matches is valid while done is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rc4_candidate_key_check (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // command
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [rc4ckc_pkg::IV_W-1:0]        iv_bytes,
    input  wire logic [rc4ckc_pkg::PART_W-1:0]      key_part0,
    input  wire logic [rc4ckc_pkg::PART_W-1:0]      key_part1,
    input  wire logic [rc4ckc_pkg::PART_W-1:0]      key_part2,
    input  wire logic [rc4ckc_pkg::PART3_W-1:0]     key_part3,
    input  wire logic [rc4ckc_pkg::EXPECT_W-1:0]    expected_stream,
    // result
    output logic                                    done,
    output logic                                    key_matches,
    // configuration
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [rc4ckc_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [rc4ckc_pkg::PDATA_W-1:0]     pwdata,
    output logic [rc4ckc_pkg::PDATA_W-1:0]          prdata,
    output logic                                    pready
);

    logic [rc4ckc_pkg::LEN_W-1:0] secret_key_length_reg;
    logic                         cfg_write;
    rc4ckc_pkg::dp_cmd_t          cmd;
    rc4ckc_pkg::dp_status_t       status;

    // Register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            secret_key_length_reg <= rc4ckc_pkg::LEN_RESET;
        end
        else if (cfg_write &&
                 (paddr[rc4ckc_pkg::PADDR_W-1:2] == rc4ckc_pkg::REG_SECRET_KEY_LENGTH))
        begin
            secret_key_length_reg <= pwdata[rc4ckc_pkg::LEN_W-1:0];
        end
    end

    // Read decode
    always_comb
    begin
        unique case (paddr[rc4ckc_pkg::PADDR_W-1:2])
            rc4ckc_pkg::REG_SECRET_KEY_LENGTH:
                prdata = rc4ckc_pkg::PDATA_W'(secret_key_length_reg);
            default:
                prdata = '0;
        endcase
    end

    rc4ckc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    rc4ckc_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .secret_key_length (secret_key_length_reg),
        .iv_bytes          (iv_bytes),
        .key_part0         (key_part0),
        .key_part1         (key_part1),
        .key_part2         (key_part2),
        .key_part3         (key_part3),
        .expected_stream   (expected_stream),
        .key_matches       (key_matches)
    );

endmodule

`default_nettype wire

/* tb/rc4_candidate_key_check_test.sv */
// ----------------------------------------------------------------------------
// rc4_candidate_key_check_test
// Self-checking bench for the RC4 candidate key check block. A short table of
// directed key tests (known vector, field extremes, length saturation, ignored
// key bytes, unmapped register) is followed by random tests in three phases of
// sender idling. Transfers are scored by an in-bench RC4 keystream predictor
// or a typed verdict; the length register is rewritten between phases and read back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc4_candidate_key_check_test;

    import rc4ckc_pkg::*;

    localparam int CYCLE_LIMIT    = 3_000_000;
    localparam int BLOCK_ITEMS    = 50;
    localparam int SETTLE_CYCLES  = 20;

    // Register index with nothing behind it
    localparam logic [PADDR_W-3:0] REG_UNMAPPED = 1'b1;

    // How a directed row is scored
    typedef enum logic [1:0] {
        BY_MODEL,       // predictor decides
        FORCED_MATCH,   // stream replaced with predicted keystream
        TYPED_HIT,      // known to match
        TYPED_MISS      // known to miss
    } row_kind_t;

    typedef struct packed {
        logic [IV_W-1:0]     iv;
        logic [PART_W-1:0]   part0;
        logic [PART_W-1:0]   part1;
        logic [PART_W-1:0]   part2;
        logic [PART3_W-1:0]  part3;
        logic [EXPECT_W-1:0] stream;
    } key_test_t;

    typedef struct packed {
        logic               set_len;
        logic [PADDR_W-3:0] reg_idx;
        logic [31:0]        reg_word;
        key_test_t          test;
        row_kind_t          kind;
    } dir_row_t;

    // "Secret" key split as three IV bytes plus "ret"; keystream of
    // "Attack at dawn" ciphertext, first six bytes
    localparam logic [IV_W-1:0]     SECRET_IV  = 24'h636553;
    localparam logic [PART_W-1:0]   SECRET_P0  = 64'h0000_0000_0074_6572;
    localparam logic [EXPECT_W-1:0] SECRET_KS  = 48'hA83C_056B_D404;
    localparam logic [PART_W-1:0]   ONES64     = '1;
    localparam logic [PART3_W-1:0]  ONES40     = '1;

    localparam dir_row_t DIRECTED_ROWS [18] = '{
        // reset length, all-zero item
        '{1'b0, REG_SECRET_KEY_LENGTH, 32'd0,
          '{24'h0, 64'h0, 64'h0, 64'h0, 40'h0, 48'h0}, BY_MODEL},
        // all-ones item
        '{1'b0, REG_SECRET_KEY_LENGTH, 32'd0,
          '{24'hFFFFFF, ONES64, ONES64, ONES64, ONES40, 48'hFFFF_FFFF_FFFF}, BY_MODEL},
        '{1'b0, REG_SECRET_KEY_LENGTH, 32'd0,
          '{24'h123456, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
            64'h0F1E_2D3C_4B5A_6978, 40'h87_96A5_B4C3, 48'h0}, FORCED_MATCH},
        // known vector, length 3
        '{1'b1, REG_SECRET_KEY_LENGTH, 32'd3,
          '{SECRET_IV, SECRET_P0, 64'h0, 64'h0, 40'h0, SECRET_KS}, TYPED_HIT},
        // first keystream byte off by one bit
        '{1'b0, REG_SECRET_KEY_LENGTH, 32'd0,
          '{SECRET_IV, SECRET_P0, 64'h0, 64'h0, 40'h0, 48'hA83C_056B_D405}, TYPED_MISS},
        // last keystream byte off by one bit
        '{1'b0, REG_SECRET_KEY_LENGTH, 32'd0,
          '{SECRET_IV, SECRET_P0, 64'h0, 64'h0, 40'h0, 48'h283C_056B_D404}, TYPED_MISS},
        // key bytes past the length are don't-care
        '{1'b0, REG_SECRET_KEY_LENGTH, 32'd0,
          '{SECRET_IV, 64'hFFFF_FFFF_FF74_6572, ONES64, ONES64, ONES40, SECRET_KS},
          TYPED_HIT},
        // write to an unmapped index leaves the length alone
        '{1'b1, REG_UNMAPPED, 32'h0000_001D,
          '{SECRET_IV, SECRET_P0, 64'h0, 64'h0, 40'h0, SECRET_KS}, TYPED_HIT},
        // length zero saturates to one
        '{1'b1, REG_SECRET_KEY_LENGTH, 32'd0,
          '{24'hABCDEF, 64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A,
            64'h3C3C_3C3C_3C3C_3C3C, 40'hC3_C3C3_C3C3, 48'h0}, FORCED_MATCH},
        '{1'b0, REG_SECRET_KEY_LENGTH, 32'd0,
          '{24'hABCDEF, 64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A,
            64'h3C3C_3C3C_3C3C_3C3C, 40'hC3_C3C3_C3C3, 48'h0}, BY_MODEL},
        // length one, upper data bits set
        '{1'b1, REG_SECRET_KEY_LENGTH, 32'hFFFF_FFE1,
          '{24'h000001, 64'h80, 64'h0, 64'h0, 40'h0, 48'h0}, FORCED_MATCH},
        // longest length
        '{1'b1, REG_SECRET_KEY_LENGTH, 32'hFFFF_FFFD,
          '{24'hFFFFFF, ONES64, ONES64, ONES64, ONES40, 48'h0}, FORCED_MATCH},
        '{1'b0, REG_SECRET_KEY_LENGTH, 32'd0,
          '{24'hFFFFFF, ONES64, ONES64, ONES64, ONES40, 48'hFFFF_FFFF_FFFF}, BY_MODEL},
        // lengths past the buffer saturate
        '{1'b1, REG_SECRET_KEY_LENGTH, 32'd30,
          '{24'h5A5A5A, 64'h1122_3344_5566_7788, 64'h99AA_BBCC_DDEE_FF00,
            64'h0102_0408_1020_4080, 40'hFE_FDFB_F7EF, 48'h0}, FORCED_MATCH},
        '{1'b1, REG_SECRET_KEY_LENGTH, 32'hFFFF_FFFF,
          '{24'h5A5A5A, 64'h1122_3344_5566_7788, 64'h99AA_BBCC_DDEE_FF00,
            64'h0102_0408_1020_4080, 40'hFE_FDFB_F7EF, 48'h0}, FORCED_MATCH},
        '{1'b1, REG_SECRET_KEY_LENGTH, 32'd2,
          '{24'h0, 64'h0, 64'h0, 64'h0, 40'h0, 48'hFFFF_FFFF_FFFF}, BY_MODEL},
        '{1'b1, REG_SECRET_KEY_LENGTH, 32'd28,
          '{24'hC0FFEE, 64'hDEAD_BEEF_CAFE_F00D, 64'h0BAD_F00D_1234_5678,
            64'h8765_4321_0FED_CBA9, 40'h13_579B_DF24, 48'h0}, FORCED_MATCH},
        '{1'b1, REG_SECRET_KEY_LENGTH, 32'd5,
          '{24'hFFFFFF, 64'h0, 64'h0, 64'h0, 40'h0, 48'h0}, BY_MODEL}
    };

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [IV_W-1:0]      iv_bytes;
    logic [PART_W-1:0]    key_part0;
    logic [PART_W-1:0]    key_part1;
    logic [PART_W-1:0]    key_part2;
    logic [PART3_W-1:0]   key_part3;
    logic [EXPECT_W-1:0]  expected_stream;
    logic                 done;
    logic                 key_matches;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    logic [LEN_W-1:0]     key_len_reg;       // bench copy of the length register
    logic                 pending_verdicts [$];
    int                   idle_pct;
    int                   error_count;
    int                   cycle_count;

    rc4_candidate_key_check dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .iv_bytes        (iv_bytes),
        .key_part0       (key_part0),
        .key_part1       (key_part1),
        .key_part2       (key_part2),
        .key_part3       (key_part3),
        .expected_stream (expected_stream),
        .done            (done),
        .key_matches     (key_matches),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 clk = ~clk;

    // RC4 key schedule plus CHECK_BYTES output steps; returns the keystream
    function automatic logic [EXPECT_W-1:0] rc4_keystream(key_test_t t,
                                                          logic [LEN_W-1:0] len_reg);
        logic [7:0]              perm [256];
        logic [7:0]              kbytes [KEY_BUFFER_BYTES];
        logic [SECRET_MAX*8-1:0] secret;
        logic [7:0]              a;
        logic [7:0]              b;
        logic [7:0]              tmp;
        logic [EXPECT_W-1:0]     ks;
        int                      secret_n;
        int                      key_n;
        int                      kidx;
        secret = {t.part3, t.part2, t.part1, t.part0};
        if (len_reg == '0)
            secret_n = 1;
        else if (int'(len_reg) > SECRET_MAX)
            secret_n = SECRET_MAX;
        else
            secret_n = int'(len_reg);
        key_n = secret_n + IV_BYTES;
        for (int k = 0; k < KEY_BUFFER_BYTES; k++)
            kbytes[k] = 8'h00;
        for (int k = 0; k < IV_BYTES; k++)
            kbytes[k] = t.iv[8*k +: 8];
        for (int k = 0; k < SECRET_MAX; k++)
            kbytes[IV_BYTES + k] = secret[8*k +: 8];
        for (int k = 0; k < 256; k++)
            perm[k] = 8'(k);

        // key schedule, key bytes used cyclically
        b    = 8'h00;
        kidx = 0;
        for (int k = 0; k < 256; k++)
        begin
            b    = b + perm[k] + kbytes[kidx];
            kidx = (kidx + 1 == key_n) ? 0 : kidx + 1;
            tmp     = perm[k];
            perm[k] = perm[b];
            perm[b] = tmp;
        end

        // output steps
        a  = 8'h00;
        b  = 8'h00;
        ks = '0;
        for (int k = 0; k < CHECK_BYTES; k++)
        begin
            a       = a + 8'd1;
            b       = b + perm[a];
            tmp     = perm[a];
            perm[a] = perm[b];
            perm[b] = tmp;
            tmp     = perm[a] + perm[b];
            if (k < CARRIED_EXPECT)
                ks[8*k +: 8] = perm[tmp];
        end
        return ks;
    endfunction

    // Present one key test; start toggles with the idle rate until transfer
    task automatic send_test(key_test_t t, logic verdict);
        @(negedge clk);
        iv_bytes        <= t.iv;
        key_part0       <= t.part0;
        key_part1       <= t.part1;
        key_part2       <= t.part2;
        key_part3       <= t.part3;
        expected_stream <= t.stream;
        forever
        begin
            start <= ($urandom_range(99) >= idle_pct);
            @(posedge clk);
            if (start && !busy)
                break;
            @(negedge clk);
        end
        pending_verdicts.push_back(verdict);
    endtask

    // Let every outstanding result come back
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write while idle, then read the length register back
    task automatic cfg_write(logic [PADDR_W-3:0] idx, logic [PDATA_W-1:0] word);
        drain();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_SECRET_KEY_LENGTH)
            key_len_reg = word[LEN_W-1:0];

        // readback
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_SECRET_KEY_LENGTH, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== PDATA_W'(key_len_reg))
        begin
            $display("%0t: secret_key_length readback mismatch, expected %0d, got %0d",
                     $time, key_len_reg, prdata);
            error_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Score each result strobe against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got key_matches=%0b",
                         $time, key_matches);
                error_count++;
            end
            else if (key_matches !== pending_verdicts[0])
            begin
                $display("%0t: key_matches mismatch, expected %0b, got %0b",
                         $time, pending_verdicts[0], key_matches);
                error_count++;
                void'(pending_verdicts.pop_front());
            end
            else
                void'(pending_verdicts.pop_front());
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        key_test_t t;
        dir_row_t  row;
        logic      verdict;
        int        mode;

        rst_n           = 1'b0;
        start           = 1'b0;
        iv_bytes        = '0;
        key_part0       = '0;
        key_part1       = '0;
        key_part2       = '0;
        key_part3       = '0;
        expected_stream = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        key_len_reg     = LEN_RESET;
        idle_pct        = 12;
        error_count     = 0;
        cycle_count     = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < $size(DIRECTED_ROWS); r++)
        begin
            row = DIRECTED_ROWS[r];
            if (row.set_len)
                cfg_write(row.reg_idx, row.reg_word);
            t = row.test;
            if (row.kind == FORCED_MATCH)
                t.stream = rc4_keystream(t, key_len_reg);
            case (row.kind)
                TYPED_HIT:  verdict = 1'b1;
                TYPED_MISS: verdict = 1'b0;
                default:    verdict = (rc4_keystream(t, key_len_reg) == t.stream);
            endcase
            send_test(t, verdict);
        end

        // random phases: sender idles 12%, then 78%, then never
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 12 : (phase == 1) ? 78 : 0;
            for (int blk = 0; blk < 3; blk++)
            begin
                cfg_write(REG_SECRET_KEY_LENGTH, $urandom());
                if ($urandom_range(3) == 0)
                    cfg_write(REG_UNMAPPED, $urandom());
                repeat (BLOCK_ITEMS)
                begin
                    t.iv    = IV_W'($urandom());
                    t.part0 = {$urandom(), $urandom()};
                    t.part1 = {$urandom(), $urandom()};
                    t.part2 = {$urandom(), $urandom()};
                    t.part3 = {8'($urandom()), $urandom()};
                    t.stream = {16'($urandom()), $urandom()};
                    // mostly true keystreams, some one bit off, some noise
                    mode = $urandom_range(9);
                    if (mode < 6)
                        t.stream = rc4_keystream(t, key_len_reg);
                    else if (mode < 8)
                        t.stream = rc4_keystream(t, key_len_reg)
                                   ^ (EXPECT_W'(1) << $urandom_range(EXPECT_W - 1));
                    send_test(t, rc4_keystream(t, key_len_reg) == t.stream);
                end
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/rc4ckc_pkg.sv
hdl/rc4ckc_ctrl.sv
hdl/rc4ckc_datapath.sv
hdl/rc4_candidate_key_check.sv
tb/rc4_candidate_key_check_test.sv
